### hw/rtl/hsf_pkg.sv
// Shared types, constants and grading helpers for the health supervisor.
package hsf_pkg;

  // Commands carried in the cmd field of an input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_ESTOP = 2'd2,
    CMD_SHUT  = 2'd3
  } cmd_t;

  // Per-service health grades
  typedef enum logic [1:0] {
    G_HEALTHY  = 2'd0,
    G_WARNING  = 2'd1,
    G_CRITICAL = 2'd2,
    G_UNKNOWN  = 2'd3
  } grade_t;

  // System modes
  typedef enum logic [2:0] {
    M_INIT     = 3'd0,
    M_STARTUP  = 3'd1,
    M_RUNNING  = 3'd2,
    M_DEGRADED = 3'd3,
    M_ERROR    = 3'd4,
    M_RECOVERY = 3'd5,
    M_SHUTDOWN = 3'd6
  } mode_t;

  // Configuration register indexes
  localparam logic [2:0] REG_CHECK_IVL = 3'd0;
  localparam logic [2:0] REG_RECOV_IVL = 3'd1;
  localparam logic [2:0] REG_AUTO_REC  = 3'd2;
  localparam logic [2:0] REG_HEALTHY_TH = 3'd3;
  localparam logic [2:0] REG_ERROR_TH  = 3'd4;

  // Configuration reset values
  localparam logic [15:0] RST_CHECK_IVL  = 16'd5000;
  localparam logic [15:0] RST_RECOV_IVL  = 16'd30000;
  localparam logic        RST_AUTO_REC   = 1'b1;
  localparam logic [6:0]  RST_HEALTHY_TH = 7'd70;
  localparam logic [6:0]  RST_ERROR_TH   = 7'd30;

  // Hardware response limits in microseconds
  localparam logic [15:0] HW_CRIT_US = 16'd5000;
  localparam logic [15:0] HW_WARN_US = 16'd2000;

  localparam logic [6:0] SCORE_FULL = 7'd100;
  localparam logic [6:0] SCORE_HALF = 7'd50;
  localparam logic [6:0] SCORE_NONE = 7'd0;

  // Raw probe flags of one tick
  typedef struct packed {
    logic        gps_connected;
    logic [3:0]  ntp_stratum;
    logic        time_service_present;
    logic        network_connected;
    logic        network_service_present;
    logic        ntp_service_present;
    logic        display_connected;
    logic        config_present;
    logic        logging_present;
    logic        metrics_present;
    logic [15:0] hw_response_us;
  } probe_t;

  // Grades and scores of one health check
  typedef struct packed {
    grade_t     gps;
    grade_t     net;
    grade_t     cfg;
    logic [6:0] overall;
    logic [6:0] gps_score;
    logic [6:0] net_score;
    logic [6:0] ntp_score;
    logic [6:0] hw_score;
  } check_t;

  // Weight of a grade toward the overall score
  function automatic logic [2:0] grade_weight(grade_t g);
    logic [2:0] w;
    case (g)
      G_HEALTHY: w = 3'd4;
      G_WARNING: w = 3'd2;
      G_UNKNOWN: w = 3'd1;
      default:   w = 3'd0;
    endcase
    return w;
  endfunction

  // Per-service percent score of a grade
  function automatic logic [6:0] grade_score(grade_t g);
    logic [6:0] s;
    case (g)
      G_HEALTHY: s = SCORE_FULL;
      G_WARNING: s = SCORE_HALF;
      default:   s = SCORE_NONE;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/hsf_grader.sv
// Combinational grading and scoring of the eight services from one probe beat.
module hsf_grader (
  input  hsf_pkg::probe_t probe,
  output hsf_pkg::check_t chk
);
  import hsf_pkg::*;

  grade_t     g_gps, g_net, g_ntp, g_disp, g_cfg, g_log, g_met, g_hw;
  logic [5:0] weight_sum;
  logic [9:0] weight_x25;

  // Grade each service
  always_comb begin
    if (!probe.gps_connected) begin
      g_gps = G_CRITICAL;
    end else if (!probe.time_service_present) begin
      g_gps = G_UNKNOWN;
    end else if (probe.ntp_stratum == 4'd1) begin
      g_gps = G_HEALTHY;
    end else if (probe.ntp_stratum <= 4'd3) begin
      g_gps = G_WARNING;
    end else begin
      g_gps = G_CRITICAL;
    end

    if (!probe.network_connected) begin
      g_net = G_CRITICAL;
    end else if (!probe.network_service_present) begin
      g_net = G_UNKNOWN;
    end else begin
      g_net = G_HEALTHY;
    end

    g_ntp  = probe.ntp_service_present ? G_HEALTHY : G_UNKNOWN;
    g_disp = probe.display_connected   ? G_HEALTHY : G_WARNING;
    g_cfg  = probe.config_present      ? G_HEALTHY : G_CRITICAL;
    g_log  = probe.logging_present     ? G_HEALTHY : G_WARNING;
    g_met  = probe.metrics_present     ? G_HEALTHY : G_WARNING;

    if (probe.hw_response_us > HW_CRIT_US) begin
      g_hw = G_CRITICAL;
    end else if (probe.hw_response_us > HW_WARN_US) begin
      g_hw = G_WARNING;
    end else begin
      g_hw = G_HEALTHY;
    end
  end

  // Sum weights; overall = sum*100/32 = sum*25/8
  always_comb begin
    weight_sum = 6'(grade_weight(g_gps)) + 6'(grade_weight(g_net))
               + 6'(grade_weight(g_ntp)) + 6'(grade_weight(g_disp))
               + 6'(grade_weight(g_cfg)) + 6'(grade_weight(g_log))
               + 6'(grade_weight(g_met)) + 6'(grade_weight(g_hw));
    weight_x25 = {weight_sum, 4'b0} + {1'b0, weight_sum, 3'b0} + {4'b0, weight_sum};
  end

  // Pack the check result
  always_comb begin
    chk.gps       = g_gps;
    chk.net       = g_net;
    chk.cfg       = g_cfg;
    chk.overall   = weight_x25[9:3];
    chk.gps_score = grade_score(g_gps);
    chk.net_score = grade_score(g_net);
    chk.ntp_score = grade_score(g_ntp);
    chk.hw_score  = grade_score(g_hw);
  end

endmodule

### hw/rtl/health_supervisor_fsm.sv
// Top level of the health supervisor: beat pipeline, timers, mode machine, config.
// Usage:
//   Input channel (in_*): one beat per 1 ms tick or command (start, emergency
//   stop, shutdown). A tick carries the raw probe flags of the eight services.
//   Result channel (out_*): exactly one result beat per input beat, in order:
//   the mode after the beat, the scores of the last health check, and the
//   check_done, state_changed and restart pulse flags.
//   Config port: APB-style, five 32-bit registers at byte offsets 0..16;
//   write only while the block is idle.
// Timing:
//   An accepted beat lands in the input register; grading, scoring and the
//   mode update then run combinationally into the result register, which
//   raises out_valid. Throughput is one beat per cycle while out_stall is low.
//   A stalled result holds; in_stall rises only when both the input register
//   and the result register are full and out_stall is high.
// Reset:
//   Synchronous active-low rst_n clears the pipeline, the clock and timers,
//   sets mode to init, grades to unknown, scores to zero and config to
//   defaults.
module health_supervisor_fsm (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic        in_gps_connected,
  input  logic [3:0]  in_ntp_stratum,
  input  logic        in_time_service_present,
  input  logic        in_network_connected,
  input  logic        in_network_service_present,
  input  logic        in_ntp_service_present,
  input  logic        in_display_connected,
  input  logic        in_config_present,
  input  logic        in_logging_present,
  input  logic        in_metrics_present,
  input  logic [15:0] in_hw_response_us,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_sys_state,
  output logic [6:0]  out_overall_score,
  output logic [6:0]  out_gps_score,
  output logic [6:0]  out_network_score,
  output logic [6:0]  out_ntp_score,
  output logic [6:0]  out_hardware_score,
  output logic        out_check_done,
  output logic        out_state_changed,
  output logic        out_restart_gps,
  output logic        out_restart_network,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hsf_pkg::*;

  // Config registers
  logic [15:0] check_ivl_r;
  logic [15:0] recov_ivl_r;
  logic        auto_rec_r;
  logic [6:0]  healthy_th_r;
  logic [6:0]  error_th_r;

  // Input register
  logic        in_valid_r;
  cmd_t        cmd_r;
  probe_t      probe_r;

  // Supervisor state
  mode_t       mode_r, mode_nxt;
  logic [31:0] time_now_r, time_now_nxt;
  logic [31:0] last_check_r, last_check_nxt;
  logic [31:0] last_rec_r, last_rec_nxt;
  grade_t      gps_grade_r, gps_grade_nxt;
  grade_t      net_grade_r, net_grade_nxt;
  logic [6:0]  overall_r, overall_nxt;
  logic [6:0]  gps_score_r, gps_score_nxt;
  logic [6:0]  net_score_r, net_score_nxt;
  logic [6:0]  ntp_score_r, ntp_score_nxt;
  logic [6:0]  hw_score_r, hw_score_nxt;

  // Result register flags
  logic        out_valid_r;
  logic        check_done_r, check_done_nxt;
  logic        changed_r, changed_nxt;
  logic        rst_gps_r, rst_gps_nxt;
  logic        rst_net_r, rst_net_nxt;

  logic        advance;
  logic        fire;
  logic        cfg_wr;
  check_t      chk;
  logic [31:0] since_check;
  logic [31:0] since_rec;
  logic        check_due;
  logic        healthy;
  logic        intact;
  mode_t       mode_chk;
  grade_t      gps_g_now, net_g_now;

  // Pipeline handshake
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Capture input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r                           <= cmd_t'(in_cmd);
      probe_r.gps_connected           <= in_gps_connected;
      probe_r.ntp_stratum             <= in_ntp_stratum;
      probe_r.time_service_present    <= in_time_service_present;
      probe_r.network_connected       <= in_network_connected;
      probe_r.network_service_present <= in_network_service_present;
      probe_r.ntp_service_present     <= in_ntp_service_present;
      probe_r.display_connected       <= in_display_connected;
      probe_r.config_present          <= in_config_present;
      probe_r.logging_present         <= in_logging_present;
      probe_r.metrics_present         <= in_metrics_present;
      probe_r.hw_response_us          <= in_hw_response_us;
    end
  end

  // Grade the held beat
  hsf_grader u_grader (
    .probe (probe_r),
    .chk   (chk)
  );

  // Next state: timers, health check, rule chain, recovery
  always_comb begin
    time_now_nxt   = time_now_r;
    last_check_nxt = last_check_r;
    last_rec_nxt   = last_rec_r;
    gps_grade_nxt  = gps_grade_r;
    net_grade_nxt  = net_grade_r;
    overall_nxt    = overall_r;
    gps_score_nxt  = gps_score_r;
    net_score_nxt  = net_score_r;
    ntp_score_nxt  = ntp_score_r;
    hw_score_nxt   = hw_score_r;
    check_done_nxt = 1'b0;
    rst_gps_nxt    = 1'b0;
    rst_net_nxt    = 1'b0;
    mode_chk       = mode_r;
    mode_nxt       = mode_r;

    since_check = time_now_r + 32'd1 - last_check_r;
    since_rec   = time_now_r + 32'd1 - last_rec_r;
    check_due   = since_check >= {16'd0, check_ivl_r};
    healthy     = chk.overall >= healthy_th_r;
    intact      = (chk.gps == G_HEALTHY || chk.gps == G_WARNING)
                  && chk.net == G_HEALTHY && chk.cfg == G_HEALTHY;
    gps_g_now   = check_due ? chk.gps : gps_grade_r;
    net_g_now   = check_due ? chk.net : net_grade_r;

    case (cmd_r)
      CMD_START: mode_nxt = M_STARTUP;
      CMD_ESTOP: mode_nxt = M_ERROR;
      CMD_SHUT:  mode_nxt = M_SHUTDOWN;
      CMD_TICK: begin
        time_now_nxt = time_now_r + 32'd1;
        if (check_due) begin
          last_check_nxt = time_now_r + 32'd1;
          check_done_nxt = 1'b1;
          gps_grade_nxt  = chk.gps;
          net_grade_nxt  = chk.net;
          overall_nxt    = chk.overall;
          gps_score_nxt  = chk.gps_score;
          net_score_nxt  = chk.net_score;
          ntp_score_nxt  = chk.ntp_score;
          hw_score_nxt   = chk.hw_score;
          if (mode_r == M_STARTUP && intact) begin
            mode_chk = M_RUNNING;
          end else if (mode_r == M_RUNNING && !healthy) begin
            mode_chk = M_DEGRADED;
          end else if (mode_r == M_DEGRADED && healthy) begin
            mode_chk = M_RUNNING;
          end else if (chk.overall < error_th_r) begin
            mode_chk = M_ERROR;
          end
        end
        mode_nxt = mode_chk;
        if (auto_rec_r && mode_chk == M_ERROR && since_rec > {16'd0, recov_ivl_r}) begin
          mode_nxt     = M_RECOVERY;
          last_rec_nxt = time_now_r + 32'd1;
          rst_gps_nxt  = gps_g_now == G_CRITICAL && probe_r.time_service_present;
          rst_net_nxt  = net_g_now == G_CRITICAL && probe_r.network_service_present;
        end
      end
      default: mode_nxt = mode_r;
    endcase

    changed_nxt = mode_nxt != mode_r;
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_INIT;
    end else if (fire) begin
      mode_r <= mode_nxt;
    end
  end

  // Timers, grades and scores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r   <= 32'd0;
      last_check_r <= 32'd0;
      last_rec_r   <= 32'd0;
      gps_grade_r  <= G_UNKNOWN;
      net_grade_r  <= G_UNKNOWN;
      overall_r    <= SCORE_NONE;
      gps_score_r  <= SCORE_NONE;
      net_score_r  <= SCORE_NONE;
      ntp_score_r  <= SCORE_NONE;
      hw_score_r   <= SCORE_NONE;
    end else if (fire) begin
      time_now_r   <= time_now_nxt;
      last_check_r <= last_check_nxt;
      last_rec_r   <= last_rec_nxt;
      gps_grade_r  <= gps_grade_nxt;
      net_grade_r  <= net_grade_nxt;
      overall_r    <= overall_nxt;
      gps_score_r  <= gps_score_nxt;
      net_score_r  <= net_score_nxt;
      ntp_score_r  <= ntp_score_nxt;
      hw_score_r   <= hw_score_nxt;
    end
  end

  // Result register: valid and per-beat flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      check_done_r <= check_done_nxt;
      changed_r    <= changed_nxt;
      rst_gps_r    <= rst_gps_nxt;
      rst_net_r    <= rst_net_nxt;
    end
  end

  // Drive result beat; mode and scores are held in the state registers
  assign out_valid           = out_valid_r;
  assign out_sys_state       = mode_r;
  assign out_overall_score   = overall_r;
  assign out_gps_score       = gps_score_r;
  assign out_network_score   = net_score_r;
  assign out_ntp_score       = ntp_score_r;
  assign out_hardware_score  = hw_score_r;
  assign out_check_done      = check_done_r;
  assign out_state_changed   = changed_r;
  assign out_restart_gps     = rst_gps_r;
  assign out_restart_network = rst_net_r;

  // Config writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_ivl_r  <= RST_CHECK_IVL;
      recov_ivl_r  <= RST_RECOV_IVL;
      auto_rec_r   <= RST_AUTO_REC;
      healthy_th_r <= RST_HEALTHY_TH;
      error_th_r   <= RST_ERROR_TH;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CHECK_IVL:  check_ivl_r  <= pwdata[15:0];
        REG_RECOV_IVL:  recov_ivl_r  <= pwdata[15:0];
        REG_AUTO_REC:   auto_rec_r   <= pwdata[0];
        REG_HEALTHY_TH: healthy_th_r <= pwdata[6:0];
        REG_ERROR_TH:   error_th_r   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Config reads
  always_comb begin
    case (paddr[4:2])
      REG_CHECK_IVL:  prdata = {16'd0, check_ivl_r};
      REG_RECOV_IVL:  prdata = {16'd0, recov_ivl_r};
      REG_AUTO_REC:   prdata = {31'd0, auto_rec_r};
      REG_HEALTHY_TH: prdata = {25'd0, healthy_th_r};
      REG_ERROR_TH:   prdata = {25'd0, error_th_r};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
